// File: hw/rtl/segint_pkg.sv
// Shared types and constants for the segment intersection unit.
// No dependencies; compiled first.
package segint_pkg;

  localparam int COORD_W = 20;          // Q12.8 coordinate width
  localparam int QMAG_W  = 21;          // quotient magnitude bits kept
  localparam int REM_W   = 64;          // divider remainder width
  localparam int DET_W   = 43;          // |det| width
  localparam int TOL_W   = 8;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t seg1_start_x;
    coord_t seg1_start_y;
    coord_t seg1_end_x;
    coord_t seg1_end_y;
    coord_t seg2_start_x;
    coord_t seg2_start_y;
    coord_t seg2_end_x;
    coord_t seg2_end_y;
  } seg_pair_t;

  // Side information that rides along with the divider pipeline.
  typedef struct packed {
    seg_pair_t pts;
    logic      neg_x;
    logic      neg_y;
    logic      det_zero;
    logic      ovf_x;
    logic      ovf_y;
  } div_ctl_t;

endpackage

// File: hw/rtl/segint_in_if.sv
// Input channel carrying one pair of segments per transfer.
// Depends on segint_pkg.
interface segint_in_if;
  logic                     valid;
  logic                     ready;
  segint_pkg::coord_t       seg1_start_x;
  segint_pkg::coord_t       seg1_start_y;
  segint_pkg::coord_t       seg1_end_x;
  segint_pkg::coord_t       seg1_end_y;
  segint_pkg::coord_t       seg2_start_x;
  segint_pkg::coord_t       seg2_start_y;
  segint_pkg::coord_t       seg2_end_x;
  segint_pkg::coord_t       seg2_end_y;

  modport source (output valid, seg1_start_x, seg1_start_y, seg1_end_x, seg1_end_y,
                  seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y, input ready);
  modport sink   (input valid, seg1_start_x, seg1_start_y, seg1_end_x, seg1_end_y,
                  seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y, output ready);
endinterface

// File: hw/rtl/segint_out_if.sv
// Result channel carrying the hit flag and the crossing point.
// Depends on segint_pkg.
interface segint_out_if;
  logic               valid;
  logic               ready;
  logic               hit;
  segint_pkg::coord_t cross_x;
  segint_pkg::coord_t cross_y;

  modport source (output valid, hit, cross_x, cross_y, input ready);
  modport sink   (input valid, hit, cross_x, cross_y, output ready);
endinterface

// File: hw/rtl/segment_intersection_unit.sv
// Segment intersection unit: line equations, determinant, two pipelined dividers.
// Depends on segint_pkg, segint_in_if and segint_out_if.
//
// The unit accepts one segment pair per clock while the output side keeps up and
// returns one result per pair, in order. Each pair passes through seven stages ahead
// of the dividers (input capture, differences and corner products, line constants,
// determinant and numerator partial products, numerator sums, magnitudes, overflow
// check), 21 restoring divider stages that each retire one quotient bit of x and y,
// and an output register. Every stage has its own valid bit and advances whenever
// the stage after it is empty or moving, so bubbles close up and a full pipeline
// holds 29 pairs while the output stalls.
// The tolerance register tol_r resets to 1 and is written through cfg_wr_en/cfg_wr_data; write it
// only while the unit holds no pairs.
module segment_intersection_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  segint_in_if.sink                  in_chan,
  segint_out_if.source               out_chan,
  input  logic                       cfg_wr_en,
  input  logic [segint_pkg::TOL_W-1:0] cfg_wr_data
);
  import segint_pkg::*;

  localparam int NDIV = QMAG_W;

  logic [TOL_W-1:0] tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_W'(1);
    end else if (cfg_wr_en) begin
      tol_r <= cfg_wr_data;
    end
  end

  // Per-stage valid bits and advance enables.
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic en1, en2, en3, en4, en5, en6, en_div0;
  logic dv_r [0:NDIV];
  logic den  [0:NDIV];
  logic out_valid_r, en_out;

  // Stage 1: captured inputs.
  seg_pair_t s1_pts_r;

  assign in_chan.ready = en1;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_pts_r.seg1_start_x <= in_chan.seg1_start_x;
      s1_pts_r.seg1_start_y <= in_chan.seg1_start_y;
      s1_pts_r.seg1_end_x   <= in_chan.seg1_end_x;
      s1_pts_r.seg1_end_y   <= in_chan.seg1_end_y;
      s1_pts_r.seg2_start_x <= in_chan.seg2_start_x;
      s1_pts_r.seg2_start_y <= in_chan.seg2_start_y;
      s1_pts_r.seg2_end_x   <= in_chan.seg2_end_x;
      s1_pts_r.seg2_end_y   <= in_chan.seg2_end_y;
    end
  end

  // Stage 2: line coefficients a, b and the four corner products of c.
  seg_pair_t                s2_pts_r;
  logic signed [20:0]       a1_r, b1_r, a2_r, b2_r;
  logic signed [39:0]       p1_r, p2_r, p3_r, p4_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_pts_r <= s1_pts_r;
      a1_r <= 21'(s1_pts_r.seg1_end_y)   - 21'(s1_pts_r.seg1_start_y);
      b1_r <= 21'(s1_pts_r.seg1_start_x) - 21'(s1_pts_r.seg1_end_x);
      a2_r <= 21'(s1_pts_r.seg2_end_y)   - 21'(s1_pts_r.seg2_start_y);
      b2_r <= 21'(s1_pts_r.seg2_start_x) - 21'(s1_pts_r.seg2_end_x);
      p1_r <= s1_pts_r.seg1_end_x   * s1_pts_r.seg1_start_y;
      p2_r <= s1_pts_r.seg1_start_x * s1_pts_r.seg1_end_y;
      p3_r <= s1_pts_r.seg2_end_x   * s1_pts_r.seg2_start_y;
      p4_r <= s1_pts_r.seg2_start_x * s1_pts_r.seg2_end_y;
    end
  end

  // Stage 3: line constants c and the two determinant products.
  seg_pair_t                s3_pts_r;
  logic signed [20:0]       a1_3_r, b1_3_r, a2_3_r, b2_3_r;
  logic signed [41:0]       c1_r, c2_r, m1_r, m2_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_pts_r <= s2_pts_r;
      a1_3_r <= a1_r;
      b1_3_r <= b1_r;
      a2_3_r <= a2_r;
      b2_3_r <= b2_r;
      c1_r <= 42'(p1_r) - 42'(p2_r);
      c2_r <= 42'(p3_r) - 42'(p4_r);
      m1_r <= 42'(a1_r) * 42'(b2_r);
      m2_r <= 42'(a2_r) * 42'(b1_r);
    end
  end

  // Stage 4: determinant and the numerator partial products. Each c is split into a
  // signed upper half and an unsigned lower half of 21 bits so that every multiplier
  // stays about 21 by 22 bits.
  seg_pair_t                s4_pts_r;
  logic signed [42:0]       det_r;
  logic signed [41:0]       n1h_r, n2h_r, n3h_r, n4h_r;
  logic signed [42:0]       n1l_r, n2l_r, n3l_r, n4l_r;

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_pts_r <= s3_pts_r;
      det_r <= 43'(m1_r) - 43'(m2_r);
      n1h_r <= b1_3_r * $signed(c2_r[41:21]);
      n2h_r <= b2_3_r * $signed(c1_r[41:21]);
      n3h_r <= a2_3_r * $signed(c1_r[41:21]);
      n4h_r <= a1_3_r * $signed(c2_r[41:21]);
      n1l_r <= b1_3_r * $signed({1'b0, c2_r[20:0]});
      n2l_r <= b2_3_r * $signed({1'b0, c1_r[20:0]});
      n3l_r <= a2_3_r * $signed({1'b0, c1_r[20:0]});
      n4l_r <= a1_3_r * $signed({1'b0, c2_r[20:0]});
    end
  end

  // Stage 5: signed numerators, recombined from the partial products.
  seg_pair_t                s5_pts_r;
  logic signed [42:0]       det5_r;
  logic signed [63:0]       nx_r, ny_r;

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_pts_r <= s4_pts_r;
      det5_r <= det_r;
      nx_r <= ((64'(n1h_r) - 64'(n2h_r)) << 21) + 64'(n1l_r) - 64'(n2l_r);
      ny_r <= ((64'(n3h_r) - 64'(n4h_r)) << 21) + 64'(n3l_r) - 64'(n4l_r);
    end
  end

  // Stage 6: magnitudes and quotient signs (truncation toward zero works on magnitudes).
  seg_pair_t                s6_pts_r;
  logic [REM_W-1:0]         anx_r, any_r;
  logic [DET_W-1:0]         ad_r;
  logic                     negx_r, negy_r, detz_r;

  always_ff @(posedge clk) begin
    if (en6) begin
      s6_pts_r <= s5_pts_r;
      anx_r  <= nx_r[63] ? REM_W'(-nx_r) : REM_W'(nx_r);
      any_r  <= ny_r[63] ? REM_W'(-ny_r) : REM_W'(ny_r);
      ad_r   <= det5_r[42] ? DET_W'(-det5_r) : DET_W'(det5_r);
      negx_r <= nx_r[63] ^ det5_r[42];
      negy_r <= ny_r[63] ^ det5_r[42];
      detz_r <= (det5_r == '0);
    end
  end

  // Divider pipeline. Entry 0 holds the overflow check; entry j retires bit NDIV-j.
  // A quotient of 2^NDIV or more is far outside every coordinate, so it is clamped.
  logic [REM_W-1:0]  rx_r [0:NDIV];
  logic [REM_W-1:0]  ry_r [0:NDIV];
  logic [NDIV-1:0]   qx_r [0:NDIV];
  logic [NDIV-1:0]   qy_r [0:NDIV];
  logic [DET_W-1:0]  d_r  [0:NDIV];
  div_ctl_t          ctl_r [0:NDIV];

  always_ff @(posedge clk) begin
    if (en_div0) begin
      rx_r[0]  <= anx_r;
      ry_r[0]  <= any_r;
      qx_r[0]  <= '0;
      qy_r[0]  <= '0;
      d_r[0]   <= ad_r;
      ctl_r[0].pts      <= s6_pts_r;
      ctl_r[0].neg_x    <= negx_r;
      ctl_r[0].neg_y    <= negy_r;
      ctl_r[0].det_zero <= detz_r;
      ctl_r[0].ovf_x    <= anx_r >= (REM_W'(ad_r) << NDIV);
      ctl_r[0].ovf_y    <= any_r >= (REM_W'(ad_r) << NDIV);
    end
  end

  for (genvar j = 1; j <= NDIV; j++) begin : g_div
    localparam int K = NDIV - j;
    logic [REM_W-1:0] dsh;
    logic             gex, gey;

    assign dsh = REM_W'(d_r[j-1]) << K;
    assign gex = rx_r[j-1] >= dsh;
    assign gey = ry_r[j-1] >= dsh;

    always_ff @(posedge clk) begin
      if (den[j]) begin
        rx_r[j]  <= gex ? rx_r[j-1] - dsh : rx_r[j-1];
        ry_r[j]  <= gey ? ry_r[j-1] - dsh : ry_r[j-1];
        qx_r[j]  <= qx_r[j-1] | (NDIV'(gex) << K);
        qy_r[j]  <= qy_r[j-1] | (NDIV'(gey) << K);
        d_r[j]   <= d_r[j-1];
        ctl_r[j] <= ctl_r[j-1];
      end
    end
  end

  // Final stage: signed quotients, range tests, saturation.
  div_ctl_t           fc;
  logic [NDIV-1:0]    magx, magy;
  logic signed [NDIV:0] px, py;
  logic               on1, on2;
  logic               hit_nxt;
  coord_t             cx_nxt, cy_nxt;
  logic               hit_r;
  coord_t             cx_r, cy_r;

  function automatic logic in_span(logic signed [NDIV:0] p, coord_t e1, coord_t e2);
    logic signed [NDIV:0] lo, hi;
    lo = (e1 < e2) ? (NDIV+1)'(e1) : (NDIV+1)'(e2);
    hi = (e1 < e2) ? (NDIV+1)'(e2) : (NDIV+1)'(e1);
    return (p >= lo) && (p <= hi);
  endfunction

  function automatic logic on_seg(logic signed [NDIV:0] qx, logic signed [NDIV:0] qy,
                                  coord_t x1, coord_t y1, coord_t x2, coord_t y2,
                                  logic [TOL_W-1:0] tol);
    logic signed [COORD_W:0] ext;
    logic [COORD_W:0]        aext;
    ext  = (COORD_W+1)'(x1) - (COORD_W+1)'(x2);
    aext = ext[COORD_W] ? (COORD_W+1)'(-ext) : (COORD_W+1)'(ext);
    if (aext > (COORD_W+1)'(tol)) return in_span(qx, x1, x2);
    return in_span(qy, y1, y2);
  endfunction

  function automatic coord_t sat_coord(logic signed [NDIV:0] v);
    if (v > (NDIV+1)'(COORD_W'(2**(COORD_W-1)-1))) return coord_t'(2**(COORD_W-1)-1);
    if (v < -(NDIV+1)'(2**(COORD_W-1)))           return coord_t'(-(2**(COORD_W-1)));
    return coord_t'(v);
  endfunction

  always_comb begin
    fc   = ctl_r[NDIV];
    magx = fc.ovf_x ? '1 : qx_r[NDIV];
    magy = fc.ovf_y ? '1 : qy_r[NDIV];
    px   = fc.neg_x ? -$signed({1'b0, magx}) : $signed({1'b0, magx});
    py   = fc.neg_y ? -$signed({1'b0, magy}) : $signed({1'b0, magy});
    on1  = on_seg(px, py, fc.pts.seg1_start_x, fc.pts.seg1_start_y,
                  fc.pts.seg1_end_x, fc.pts.seg1_end_y, tol_r);
    on2  = on_seg(px, py, fc.pts.seg2_start_x, fc.pts.seg2_start_y,
                  fc.pts.seg2_end_x, fc.pts.seg2_end_y, tol_r);
    hit_nxt = !fc.det_zero && on1 && on2;
    cx_nxt  = hit_nxt ? sat_coord(px) : '0;
    cy_nxt  = hit_nxt ? sat_coord(py) : '0;
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      hit_r <= hit_nxt;
      cx_r  <= cx_nxt;
      cy_r  <= cy_nxt;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.hit     = hit_r;
  assign out_chan.cross_x = cx_r;
  assign out_chan.cross_y = cy_r;

  // Each stage moves when the next one is empty or moving.
  assign en_out  = !out_valid_r || out_chan.ready;
  assign den[NDIV] = !dv_r[NDIV] || en_out;
  for (genvar j = 0; j < NDIV; j++) begin : g_en
    assign den[j] = !dv_r[j] || den[j+1];
  end
  assign en_div0 = den[0];
  assign en6 = !v6_r || en_div0;
  assign en5 = !v5_r || en6;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1)     v1_r <= in_chan.valid;
      if (en2)     v2_r <= v1_r;
      if (en3)     v3_r <= v2_r;
      if (en4)     v4_r <= v3_r;
      if (en5)     v5_r <= v4_r;
      if (en6)     v6_r <= v5_r;
      if (en_out)  out_valid_r <= dv_r[NDIV];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (en_div0) begin
      dv_r[0] <= v6_r;
    end
  end

  for (genvar j = 1; j <= NDIV; j++) begin : g_dv
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j] <= 1'b0;
      end else if (den[j]) begin
        dv_r[j] <= dv_r[j-1];
      end
    end
  end

  // A missed result always reports the origin.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !hit_r |-> (cx_r == '0) && (cy_r == '0))
    else $error("miss result carries a nonzero point");

  // Without overflow the divider leaves a remainder below the divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r[NDIV] && !fc.det_zero && !fc.ovf_x && !fc.ovf_y |->
      (rx_r[NDIV] < REM_W'(d_r[NDIV])) && (ry_r[NDIV] < REM_W'(d_r[NDIV])))
    else $error("divider remainder not reduced");

  // The input side only stalls behind a full pipeline and a waiting result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> out_valid_r && !out_chan.ready && dv_r[NDIV])
    else $error("input stalled without a blocked output");

endmodule
